// ----- hdl/assert_macros.svh -----
// assertion helpers for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational invariant, checked at every rising clock edge out of reset
`define SID_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// implication checked at every rising clock edge out of reset
`define SID_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg
// Sizes and shared types of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sid_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 8;

   localparam int IN_W  = 16;                    // port width of a coordinate
   localparam int OUT_W = 32;                    // port width of a point coordinate
   localparam int CW    = COORD_WIDTH;
   localparam int DW    = CW + 1;                // coordinate difference
   localparam int PW    = 2 * DW;                // product of two differences
   localparam int NW    = PW + 1;                // det, tn, sn
   localparam int MW    = NW - 1;                // magnitude of det or tn
   localparam int LH    = MW / 2;                // low part of tn magnitude
   localparam int HH    = MW - LH;               // high part of tn magnitude
   localparam int XW    = DW + MW + FRAC_BITS;   // dividend and quotient
   localparam int RW    = MW + 1;                // partial remainder
   localparam int QTW   = (XW < 63) ? XW : 63;
   localparam int BSW   = CW + FRAC_BITS;
   localparam int SW0   = ((QTW > BSW) ? QTW : BSW) + 2;
   localparam int SW    = (SW0 > 34) ? SW0 : 34; // point sum before saturation

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic                  neg;
      logic signed [CW-1:0]  base;
      logic [XW-1:0]         dividend;
      logic [MW-1:0]         divisor;
   } div_in_type;

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic                  neg;
      logic signed [CW-1:0]  base;
      logic [XW-1:0]         quot;
   } div_out_type;

endpackage

// ----- hdl/sid_front.sv -----
// ----------------------------------------------------------------------------
// sid_front
// Differences, products, determinant and numerators, range tests and the
// dividend of each coordinate, over six register stages.
// ----------------------------------------------------------------------------
module sid_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    line_mode,
   input  logic                    req_valid,
   input  logic [15:0]             req_a_x,
   input  logic [15:0]             req_a_y,
   input  logic [15:0]             req_b_x,
   input  logic [15:0]             req_b_y,
   input  logic [15:0]             req_c_x,
   input  logic [15:0]             req_c_y,
   input  logic [15:0]             req_d_x,
   input  logic [15:0]             req_d_y,
   output sid_pkg::div_in_type     div_x,
   output sid_pkg::div_in_type     div_y
);
   import sid_pkg::*;

   localparam int PLW = DW + LH;
   localparam int PHW = DW + HH;

   typedef struct packed {
      logic                  valid;
      logic signed [CW-1:0]  ax, ay;
      logic signed [DW-1:0]  rx, ry, qx, qy, wx, wy;
   } st1_type;

   typedef struct packed {
      logic                  valid;
      logic signed [CW-1:0]  ax, ay;
      logic signed [DW-1:0]  rx, ry;
      logic signed [PW-1:0]  p_rxqy, p_ryqx, p_qywx, p_qxwy, p_rxwy, p_rywx;
   } st2_type;

   typedef struct packed {
      logic                  valid;
      logic signed [CW-1:0]  ax, ay;
      logic signed [DW-1:0]  rx, ry;
      logic signed [NW-1:0]  det, tn, sn;
   } st3_type;

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic                  neg_x, neg_y;
      logic signed [CW-1:0]  ax, ay;
      logic [DW-1:0]         rx_mag, ry_mag;
      logic [MW-1:0]         tn_mag, det_mag;
   } st4_type;

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic                  neg_x, neg_y;
      logic signed [CW-1:0]  ax, ay;
      logic [MW-1:0]         det_mag;
      logic [PLW-1:0]        px_lo, py_lo;
      logic [PHW-1:0]        px_hi, py_hi;
   } st5_type;

   st1_type st1_in, st1_ff;
   st2_type st2_in, st2_ff;
   st3_type st3_in, st3_ff;
   st4_type st4_in, st4_ff;
   st5_type st5_in, st5_ff;
   div_in_type dx_in, dx_ff, dy_in, dy_ff;

   // low COORD_WIDTH bits of a port, sign extended where the port is narrower
   function automatic logic signed [CW-1:0] get_coord(input logic [IN_W-1:0] v);
      logic [CW-1:0] r;
      for (int i = 0; i < CW; i++) begin
         r[i] = v[(i < IN_W) ? i : IN_W - 1];
      end
      return signed'(r);
   endfunction

   function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] m);
      return DW'(p) - DW'(m);
   endfunction

   function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   always_comb begin
      logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
      ax = get_coord(req_a_x);
      ay = get_coord(req_a_y);
      bx = get_coord(req_b_x);
      by = get_coord(req_b_y);
      cx = get_coord(req_c_x);
      cy = get_coord(req_c_y);
      dx = get_coord(req_d_x);
      dy = get_coord(req_d_y);
      st1_in.valid = req_valid;
      st1_in.ax    = ax;
      st1_in.ay    = ay;
      st1_in.rx    = diff(bx, ax);
      st1_in.ry    = diff(by, ay);
      st1_in.qx    = diff(cx, dx);
      st1_in.qy    = diff(cy, dy);
      st1_in.wx    = diff(cx, ax);
      st1_in.wy    = diff(cy, ay);
   end

   always_comb begin
      st2_in.valid  = st1_ff.valid;
      st2_in.ax     = st1_ff.ax;
      st2_in.ay     = st1_ff.ay;
      st2_in.rx     = st1_ff.rx;
      st2_in.ry     = st1_ff.ry;
      st2_in.p_rxqy = PW'(st1_ff.rx) * PW'(st1_ff.qy);
      st2_in.p_ryqx = PW'(st1_ff.ry) * PW'(st1_ff.qx);
      st2_in.p_qywx = PW'(st1_ff.qy) * PW'(st1_ff.wx);
      st2_in.p_qxwy = PW'(st1_ff.qx) * PW'(st1_ff.wy);
      st2_in.p_rxwy = PW'(st1_ff.rx) * PW'(st1_ff.wy);
      st2_in.p_rywx = PW'(st1_ff.ry) * PW'(st1_ff.wx);
   end

   always_comb begin
      st3_in.valid = st2_ff.valid;
      st3_in.ax    = st2_ff.ax;
      st3_in.ay    = st2_ff.ay;
      st3_in.rx    = st2_ff.rx;
      st3_in.ry    = st2_ff.ry;
      st3_in.det   = NW'(st2_ff.p_rxqy) - NW'(st2_ff.p_ryqx);
      st3_in.tn    = NW'(st2_ff.p_qywx) - NW'(st2_ff.p_qxwy);
      st3_in.sn    = NW'(st2_ff.p_rxwy) - NW'(st2_ff.p_rywx);
   end

   // fold the determinant sign into the numerators, then test 0 <= t,s <= 1
   always_comb begin
      logic                 dneg, in_range;
      logic signed [NW-1:0] det2, tn2, sn2;
      dneg     = st3_ff.det[NW-1];
      det2     = dneg ? -st3_ff.det : st3_ff.det;
      tn2      = dneg ? -st3_ff.tn  : st3_ff.tn;
      sn2      = dneg ? -st3_ff.sn  : st3_ff.sn;
      in_range = !(tn2[NW-1] || (tn2 > det2) || sn2[NW-1] || (sn2 > det2));
      st4_in.valid   = st3_ff.valid;
      st4_in.hit     = (st3_ff.det != '0) && (line_mode || in_range);
      st4_in.neg_x   = st3_ff.rx[DW-1] ^ tn2[NW-1];
      st4_in.neg_y   = st3_ff.ry[DW-1] ^ tn2[NW-1];
      st4_in.ax      = st3_ff.ax;
      st4_in.ay      = st3_ff.ay;
      st4_in.rx_mag  = mag_d(st3_ff.rx);
      st4_in.ry_mag  = mag_d(st3_ff.ry);
      st4_in.tn_mag  = tn2[NW-1] ? MW'(-tn2) : MW'(tn2);
      st4_in.det_mag = MW'(det2);
   end

   // r*tn as two partial products on the halves of tn
   always_comb begin
      st5_in.valid   = st4_ff.valid;
      st5_in.hit     = st4_ff.hit;
      st5_in.neg_x   = st4_ff.neg_x;
      st5_in.neg_y   = st4_ff.neg_y;
      st5_in.ax      = st4_ff.ax;
      st5_in.ay      = st4_ff.ay;
      st5_in.det_mag = st4_ff.det_mag;
      st5_in.px_lo   = PLW'(st4_ff.rx_mag) * PLW'(st4_ff.tn_mag[LH-1:0]);
      st5_in.py_lo   = PLW'(st4_ff.ry_mag) * PLW'(st4_ff.tn_mag[LH-1:0]);
      st5_in.px_hi   = PHW'(st4_ff.rx_mag) * PHW'(st4_ff.tn_mag[MW-1:LH]);
      st5_in.py_hi   = PHW'(st4_ff.ry_mag) * PHW'(st4_ff.tn_mag[MW-1:LH]);
   end

   always_comb begin
      dx_in.valid    = st5_ff.valid;
      dx_in.hit      = st5_ff.hit;
      dx_in.neg      = st5_ff.neg_x;
      dx_in.base     = st5_ff.ax;
      dx_in.divisor  = st5_ff.det_mag;
      dx_in.dividend = (XW'(st5_ff.px_lo) + (XW'(st5_ff.px_hi) << LH)) << FRAC_BITS;
      dy_in.valid    = st5_ff.valid;
      dy_in.hit      = st5_ff.hit;
      dy_in.neg      = st5_ff.neg_y;
      dy_in.base     = st5_ff.ay;
      dy_in.divisor  = st5_ff.det_mag;
      dy_in.dividend = (XW'(st5_ff.py_lo) + (XW'(st5_ff.py_hi) << LH)) << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff.valid <= 1'b0;
         st2_ff.valid <= 1'b0;
         st3_ff.valid <= 1'b0;
         st4_ff.valid <= 1'b0;
         st5_ff.valid <= 1'b0;
         dx_ff.valid  <= 1'b0;
         dy_ff.valid  <= 1'b0;
      end else if (en) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         st5_ff <= st5_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
      end
   end

   assign div_x = dx_ff;
   assign div_y = dy_ff;

endmodule

// ----- hdl/sid_div.sv -----
// ----------------------------------------------------------------------------
// sid_div
// Pipelined restoring divider, one quotient bit per register stage, with the
// point's side data travelling alongside.
// ----------------------------------------------------------------------------
module sid_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  sid_pkg::div_in_type     div_in,
   output sid_pkg::div_out_type    div_out
);
   import sid_pkg::*;

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic                  neg;
      logic signed [CW-1:0]  base;
      logic [RW-1:0]         rem;
      logic [XW-1:0]         num;
      logic [XW-1:0]         quot;
      logic [MW-1:0]         divisor;
   } dstage_type;

   dstage_type first;
   dstage_type stage_in [XW];
   dstage_type stage_ff [XW];

   function automatic dstage_type step(input dstage_type s);
      dstage_type    r;
      logic [RW-1:0] t;
      logic          qbit;
      r    = s;
      t    = {s.rem[RW-2:0], s.num[XW-1]};
      qbit = (t >= RW'(s.divisor));
      r.rem  = qbit ? (t - RW'(s.divisor)) : t;
      r.num  = s.num << 1;
      r.quot = {s.quot[XW-2:0], qbit};
      return r;
   endfunction

   always_comb begin
      first.valid   = div_in.valid;
      first.hit     = div_in.hit;
      first.neg     = div_in.neg;
      first.base    = div_in.base;
      first.rem     = '0;
      first.num     = div_in.dividend;
      first.quot    = '0;
      first.divisor = div_in.divisor;
   end

   always_comb begin
      stage_in[0] = step(first);
      for (int k = 1; k < XW; k++) begin
         stage_in[k] = step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < XW; k++) begin
            stage_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < XW; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign div_out.valid = stage_ff[XW-1].valid;
   assign div_out.hit   = stage_ff[XW-1].hit;
   assign div_out.neg   = stage_ff[XW-1].neg;
   assign div_out.base  = stage_ff[XW-1].base;
   assign div_out.quot  = stage_ff[XW-1].quot;

endmodule

// ----- hdl/sid_back.sv -----
// ----------------------------------------------------------------------------
// sid_back
// Signs the quotients, adds the start point, saturates and holds the
// response register.
// ----------------------------------------------------------------------------
module sid_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  sid_pkg::div_out_type    quo_x,
   input  sid_pkg::div_out_type    quo_y,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic signed [31:0]      rsp_inter_x,
   output logic signed [31:0]      rsp_inter_y,
   output logic                    rsp_clipped
);
   import sid_pkg::*;

   typedef struct packed {
      logic                     clip;
      logic signed [OUT_W-1:0]  val;
   } coord_type;

   localparam logic signed [SW-1:0] MAX_V = SW'(32'sh7fffffff);
   localparam logic signed [SW-1:0] MIN_V = SW'(32'sh80000000);

   logic                     valid_ff;
   logic                     hit_ff, hit_in;
   logic signed [OUT_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic                     clip_ff, clip_in;
   coord_type                cx, cy;

   // quotient above 2^62 saturates before the add
   function automatic logic over_limit(input logic [XW-1:0] q);
      logic above, at62, below;
      above = 1'b0;
      at62  = 1'b0;
      below = 1'b0;
      for (int i = 0; i < XW; i++) begin
         if (i > 62) above = above | q[i];
         else if (i == 62) at62 = q[i];
         else below = below | q[i];
      end
      return above | (at62 & below);
   endfunction

   function automatic coord_type sat_coord(input div_out_type d);
      coord_type           r;
      logic signed [SW-1:0] b, qs, sum;
      b   = SW'(d.base);
      b   = b <<< FRAC_BITS;
      qs  = signed'(SW'(d.quot));
      qs  = d.neg ? -qs : qs;
      sum = b + qs;
      if (over_limit(d.quot)) begin
         r.clip = 1'b1;
         r.val  = d.neg ? MIN_V[OUT_W-1:0] : MAX_V[OUT_W-1:0];
      end else if (sum > MAX_V) begin
         r.clip = 1'b1;
         r.val  = MAX_V[OUT_W-1:0];
      end else if (sum < MIN_V) begin
         r.clip = 1'b1;
         r.val  = MIN_V[OUT_W-1:0];
      end else begin
         r.clip = 1'b0;
         r.val  = sum[OUT_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      cx      = sat_coord(quo_x);
      cy      = sat_coord(quo_y);
      hit_in  = quo_x.hit;
      x_in    = quo_x.hit ? cx.val : '0;
      y_in    = quo_x.hit ? cy.val : '0;
      clip_in = quo_x.hit & (cx.clip | cy.clip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= quo_x.valid;
      end
      if (en) begin
         hit_ff  <= hit_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_inter_x = x_ff;
   assign rsp_inter_y = y_ff;
   assign rsp_clipped = clip_ff;

endmodule

// ----- hdl/segment_intersection_2d_top.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_2d_top
// Intersection of two 2d segments or lines, one request per cycle.
// ----------------------------------------------------------------------------
// One request enters every cycle while the response side is not stalled; a
// response passes through 6 front stages, one divider stage per quotient bit
// (at 16-bit coordinates and 8 fractional bits) and one output register. The
// depth is set by the two restoring dividers, which retire one quotient bit
// per stage. A stalled response holds the whole pipeline, and the request
// side with it.
`include "assert_macros.svh"

module segment_intersection_2d_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_a_x,
   input  logic signed [15:0] req_a_y,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_c_x,
   input  logic signed [15:0] req_c_y,
   input  logic signed [15:0] req_d_x,
   input  logic signed [15:0] req_d_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_inter_x,
   output logic signed [31:0] rsp_inter_y,
   output logic               rsp_clipped
);
   import sid_pkg::*;

   logic        line_mode_ff;
   logic        en;
   div_in_type  div_x, div_y;
   div_out_type quo_x, quo_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_mode_ff <= 1'b0;
      end else if (csr_we) begin
         line_mode_ff <= csr_wdata;
      end
   end

   // the pipeline moves whenever the response register is free or taken
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   sid_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .line_mode (line_mode_ff),
      .req_valid (req_valid),
      .req_a_x   (req_a_x),
      .req_a_y   (req_a_y),
      .req_b_x   (req_b_x),
      .req_b_y   (req_b_y),
      .req_c_x   (req_c_x),
      .req_c_y   (req_c_y),
      .req_d_x   (req_d_x),
      .req_d_y   (req_d_y),
      .div_x     (div_x),
      .div_y     (div_y)
   );

   sid_div u_div_x (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_in  (div_x),
      .div_out (quo_x)
   );

   sid_div u_div_y (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_in  (div_y),
      .div_out (quo_y)
   );

   sid_back u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .quo_x       (quo_x),
      .quo_y       (quo_y),
      .rsp_valid   (rsp_valid),
      .rsp_hit     (rsp_hit),
      .rsp_inter_x (rsp_inter_x),
      .rsp_inter_y (rsp_inter_y),
      .rsp_clipped (rsp_clipped)
   );

   // both dividers carry the same request in the same slot
   `SID_ASSERT(a_div_lockstep, (quo_x.valid == quo_y.valid) && (!quo_x.valid || (quo_x.hit == quo_y.hit)))
   // a miss carries an all-zero point
   `SID_ASSERT_IMPL(a_miss_zero, rsp_valid && !rsp_hit, ({rsp_inter_x, rsp_inter_y} == '0) && !rsp_clipped)
   // a saturated point only ever comes with a hit
   `SID_ASSERT_IMPL(a_clip_hit, rsp_valid && rsp_clipped, rsp_hit)

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives segment pairs through segment_intersection_2d_top in segment and
// line mode. Predicted hits and points are kept in a queue and compared
// field by field with each response, under random idling and stalls.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic signed [15:0] ax, ay, bx, by, cx, cy, dx, dy;
   } seg_pair_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] px, py;
      logic               clipped;
   } crossing_type;

   class crossing_board;
      crossing_type pending[$];
      logic         line_mode = 1'b0;
      int           errors = 0;

      // fixed point coordinate: base + r*tn/det, truncated, saturated
      function automatic logic signed [31:0] place(longint base, longint rd, longint tn,
                                                   longint det, ref logic clip);
         logic signed [127:0] num, q, sum;
         num = 128'(rd) * 128'(tn) * 128'sd256;
         q   = num / 128'(det);
         sum = 128'(base) * 128'sd256 + q;
         if (sum > 128'sd2147483647) begin
            clip = 1'b1;
            return 32'h7fff_ffff;
         end
         if (sum < -128'sd2147483648) begin
            clip = 1'b1;
            return 32'h8000_0000;
         end
         return sum[31:0];
      endfunction

      function void note(seg_pair_type s);
         crossing_type e;
         longint       rx, ry, qx, qy, wx, wy, det, tn, sn;
         logic         clip;
         e = '{1'b0, 32'sd0, 32'sd0, 1'b0};
         rx = longint'(s.bx) - s.ax;  ry = longint'(s.by) - s.ay;
         qx = longint'(s.cx) - s.dx;  qy = longint'(s.cy) - s.dy;
         wx = longint'(s.cx) - s.ax;  wy = longint'(s.cy) - s.ay;
         det = rx * qy - ry * qx;
         tn  = qy * wx - qx * wy;
         sn  = rx * wy - ry * wx;
         clip = 1'b0;
         if (det < 0) begin
            det = -det; tn = -tn; sn = -sn;
         end
         if (det != 0 && (line_mode || (tn >= 0 && tn <= det && sn >= 0 && sn <= det)))
            begin
            e.hit = 1'b1;
            e.px = place(s.ax, rx, tn, det, clip);
            e.py = place(s.ay, ry, tn, det, clip);
            e.clipped = clip;
         end
         pending.push_back(e);
      endfunction

      function void cmp(string name, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
         end
      endfunction

      function void check(crossing_type a);
         crossing_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual hit %0d", $time, a.hit);
            return;
         end
         e = pending.pop_front();
         cmp("hit", e.hit, a.hit);
         cmp("inter_x", e.px, a.px);
         cmp("inter_y", e.py, a.py);
         cmp("clipped", e.clipped, a.clipped);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic               csr_wdata = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   logic signed [15:0] req_c_x = '0, req_c_y = '0, req_d_x = '0, req_d_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;
   logic signed [31:0] rsp_inter_x, rsp_inter_y;
   logic               rsp_clipped;

   crossing_board board = new();
   int    stall_pct = 0;
   int    hold_ask = 0, hold_seen = 0, hold_left = 0;
   int    cycles = 0;
   localparam int CYCLE_LIMIT = 400000;

   segment_intersection_2d_top i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_b_x(req_b_x), .req_b_y(req_b_y),
      .req_c_x(req_c_x), .req_c_y(req_c_y), .req_d_x(req_d_x), .req_d_y(req_d_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit), .rsp_inter_x(rsp_inter_x), .rsp_inter_y(rsp_inter_y),
      .rsp_clipped(rsp_clipped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** segment_intersection_2d_top: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_ask) begin
         hold_seen <= hold_ask;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // outputs are settled at the falling edge; accepted at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check('{rsp_hit, rsp_inter_x, rsp_inter_y, rsp_clipped});
   end

   task automatic send(seg_pair_type s, int idle_pct);
      logic taken;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_x <= s.ax; req_a_y <= s.ay; req_b_x <= s.bx; req_b_y <= s.by;
      req_c_x <= s.cx; req_c_y <= s.cy; req_d_x <= s.dx; req_d_y <= s.dy;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      board.note(s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_mode(logic m);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      board.line_mode = m;
   endtask

   function automatic logic signed [15:0] coord(int kind);
      logic signed [15:0] pick[5] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1};
      case (kind)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 127)) - 64);
         default: return pick[$urandom_range(0, 4)];
      endcase
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type s;
      int           kind, pick, k;
      pick = $urandom_range(0, 99);
      kind = (pick < 35) ? 0 : (pick < 80) ? 1 : 2;
      s = '{coord(kind), coord(kind), coord(kind), coord(kind),
            coord(kind), coord(kind), coord(kind), coord(kind)};
      // parallel or collinear pair
      if (pick >= 90) begin
         k = $urandom_range(0, 3) - 1;
         s.dx = s.cx + 16'(k * (s.bx - s.ax));
         s.dy = s.cy + 16'(k * (s.by - s.ay));
      end
      return s;
   endfunction

   seg_pair_type directed[$] = '{
      '{0, 0, 10, 10, 0, 10, 10, 0},                     // plain crossing
      '{0, 0, 10, 0, 0, 5, 10, 5},                       // parallel
      '{0, 0, 10, 0, 2, 0, 8, 0},                        // collinear
      '{3, 3, 3, 3, 0, 0, 5, 5},                         // zero-length segment
      '{0, 0, 10, 0, 0, -5, 0, 5},                       // touch at t = 0
      '{0, 0, 10, 0, 10, -5, 10, 5},                     // touch at t = 1
      '{0, 0, 10, 0, 5, 0, 5, 5},                        // touch at s = 0
      '{0, 0, 10, 0, 5, 5, 5, 0},                        // touch at s = 1
      '{0, 0, 10, 0, 11, -5, 11, 5},                     // just beyond t = 1
      '{0, 0, 3, 1, 0, 1, 3, 0},                         // fractional point
      '{-3, 0, 3, -1, -3, -1, 3, 0},                     // negative fractions
      '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
      '{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768},
      '{-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32766},
      '{-32768, 0, -32767, 0, 32767, -32768, 32767, 32767},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32767, -32767, 32767, 32766, 32766, 32767},
      '{0, 0, 1, 1, -1, -1, 1, 1},
      '{-1, -1, -1, -1, -1, -1, -1, -1}
   };

   initial begin
      int idle_tab[6] = '{0, 81, 0, 81, 22, 0};
      int stall_tab[6] = '{0, 0, 81, 81, 22, 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int m = 0; m < 2; m++) begin
         set_mode(m[0]);
         foreach (directed[i])
            send(directed[i], 0);
         drain();
      end
      for (int p = 0; p < 12; p++) begin
         set_mode(p[0]);
         stall_pct = stall_tab[p % 6];
         for (int i = 0; i < 65; i++)
            send(random_pair(), idle_tab[p % 6]);
         // block fills up behind a long response hold-off
         if (p == 5) begin
            hold_ask = hold_ask + 1;
            for (int i = 0; i < 80; i++)
               send(random_pair(), 0);
         end
         drain();
      end
      set_mode(1'b0);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("** segment_intersection_2d_top: PASSED **");
      else
         $display("** segment_intersection_2d_top: FAILED **");
      $finish;
   end

endmodule
